// ===== rtl/core/nwha_pkg.sv =====
// ----------------------------------------------------------------------------
// nwha_pkg: shared types and constants
// Register indexes, sequencer states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package nwha_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax     = 24;
   localparam int CsrIndexWidth      = 3;
   localparam int CsrDataWidth       = 16;

   localparam logic [CsrIndexWidth-1:0] REG_SWEEP_RANGE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_WALL_LIMIT    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_HEADING_SET   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_ALIGN_TOL     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_TURN_SPEED    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_FORWARD_SPEED = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_TURN      = 3'd6;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_FORWARD   = 3'd7;

   // CORDIC datapath width: d*39797 < 2^32, x grows by gain ~1.65
   localparam int CordicWidth = 36;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT_RUN,
      ST_LOCK,
      ST_VEC_START,
      ST_VEC_RUN,
      ST_DECIDE,
      ST_OUT
   } seq_state_type;

   typedef enum logic [0:0] {
      MODE_ROTATE,
      MODE_VECTOR
   } cordic_mode_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
   } cordic_ctrl_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/nwha_cordic.sv =====
// ----------------------------------------------------------------------------
// nwha_cordic: shared iterative CORDIC unit
// One micro-rotation per cycle, rotation or vectoring mode, floor shifts.
// ----------------------------------------------------------------------------
module nwha_cordic #(
   parameter int CORDIC_STEPS = nwha_pkg::CordicStepsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nwha_pkg::cordic_ctrl_type             ctrl,
   input  logic signed [nwha_pkg::CordicWidth-1:0] x_init,
   input  logic signed [nwha_pkg::CordicWidth-1:0] y_init,
   input  logic signed [32:0]                    z_init,
   output logic                                  busy,
   output logic                                  done,
   output logic signed [nwha_pkg::CordicWidth-1:0] x_out,
   output logic signed [nwha_pkg::CordicWidth-1:0] y_out,
   output logic signed [32:0]                    z_out
);
   import nwha_pkg::*;

   localparam int Steps = (CORDIC_STEPS > CordicStepsMax) ? CordicStepsMax : CORDIC_STEPS;
   localparam logic [4:0] LastStep = 5'(Steps - 1);

   logic signed [CordicWidth-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0]            z_ff, z_in;
   logic [4:0]                    step_ff, step_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   cordic_mode_type               mode_ff, mode_in;

   logic                          dir_pos;
   logic signed [CordicWidth-1:0] xs, ys;
   logic signed [32:0]            at;

   always_comb begin
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      at      = $signed({1'b0, atan_entry(step_ff)});
      dir_pos = (mode_ff == MODE_ROTATE) ? !z_ff[32] : !y_ff[CordicWidth-1];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      if (ctrl.start) begin
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
         step_in = '0;
         busy_in = 1'b1;
         mode_in = ctrl.mode;
      end else if (busy_ff) begin
         if (dir_pos) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
         end
         if (mode_ff == MODE_VECTOR) begin
            x_in = dir_pos ? x_ff + ys : x_ff - ys;
            y_in = dir_pos ? y_ff - xs : y_ff + xs;
            z_in = dir_pos ? z_ff + at : z_ff - at;
         end else begin
            z_in = dir_pos ? z_ff - at : z_ff + at;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      mode_ff <= mode_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy)) else $error("done without busy");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> step_ff <= LastStep) else $error("step overrun");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy) else $error("done while busy");

endmodule

// ===== rtl/core/nearest_wall_heading_aligner.sv =====
// ----------------------------------------------------------------------------
// nearest_wall_heading_aligner: nearest wall lock and heading alignment
// Tracks the nearest in-window sample, locks a world target at scan end
// and steers toward it with CORDIC rotation and vectoring.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  req     | req_operation .. req_pose_yaw | req_valid / req_stall
//  rsp     | rsp_forward_velocity .. held  | rsp_valid / rsp_stall
//  csr     | csr_write, csr_index, csr_data| write enable only
//
// Samples and lock clears are taken without leaving the idle state.
// A scan-end word that forms a lock runs rotation then vectoring on the one
// shared CORDIC unit; with a lock already held it runs vectoring only, and
// with no lock it runs neither before the decision.
// Reset is synchronous; the lock and nearest tracker come up cleared.
// req_stall is high while a scan-end word is in work; a result still waiting
// on rsp_stall holds the next scan-end word at its decision step.
module nearest_wall_heading_aligner #(
   parameter int CORDIC_STEPS = nwha_pkg::CordicStepsDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic                                   req_sample_present,
   input  logic [15:0]                            req_sample_angle,
   input  logic [15:0]                            req_sample_distance,
   input  logic                                   req_last_of_scan,
   input  logic signed [23:0]                     req_pose_x,
   input  logic signed [23:0]                     req_pose_y,
   input  logic [15:0]                            req_pose_yaw,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [14:0]                            rsp_forward_velocity,
   output logic signed [15:0]                     rsp_turn_velocity,
   output logic                                   rsp_aligned,
   output logic                                   rsp_target_held,
   input  logic                                   csr_write,
   input  logic [nwha_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [nwha_pkg::CsrDataWidth-1:0]      csr_data
);
   import nwha_pkg::*;

   localparam int W = CordicWidth;

   // configuration
   logic [15:0] sweep_ff, wall_ff;
   logic signed [15:0] hset_ff, fwd_ff;
   logic [14:0] tol_ff, turn_ff, maxturn_ff, maxfwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff   <= 16'd16384;
         wall_ff    <= 16'd512;
         hset_ff    <= 16'sd0;
         tol_ff     <= 15'd182;
         turn_ff    <= 15'd2048;
         fwd_ff     <= 16'sd410;
         maxturn_ff <= 15'd11633;
         maxfwd_ff  <= 15'd901;
      end else if (csr_write) begin
         case (csr_index)
            REG_SWEEP_RANGE:   sweep_ff   <= csr_data;
            REG_WALL_LIMIT:    wall_ff    <= csr_data;
            REG_HEADING_SET:   hset_ff    <= csr_data;
            REG_ALIGN_TOL:     tol_ff     <= csr_data[14:0];
            REG_TURN_SPEED:    turn_ff    <= csr_data[14:0];
            REG_FORWARD_SPEED: fwd_ff     <= csr_data;
            REG_MAX_TURN:      maxturn_ff <= csr_data[14:0];
            REG_MAX_FORWARD:   maxfwd_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // state
   seq_state_type state_ff, state_in;
   logic        lock_ff, lock_in, seen_ff, seen_in;
   logic signed [23:0] lockx_ff, lockx_in, locky_ff, locky_in;
   logic [15:0] brange_ff, brange_in, bbear_ff, bbear_in;
   logic signed [23:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] yaw_ff, yaw_in;
   logic signed [24:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0] err_ff, err_in;
   logic        zero_ff, zero_in;
   logic        rv_ff, rv_in;
   logic [14:0] rfwd_ff, rfwd_in;
   logic signed [15:0] rturn_ff, rturn_in;
   logic        ral_ff, ral_in, rheld_ff, rheld_in;

   cordic_ctrl_type  cctl;
   logic signed [W-1:0] cx0, cy0, cx, cy;
   logic signed [32:0]  cz0, cz;
   logic                cbusy, cdone;

   nwha_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .ctrl(cctl),
      .x_init(cx0), .y_init(cy0), .z_init(cz0),
      .busy(cbusy), .done(cdone), .x_out(cx), .y_out(cy), .z_out(cz)
   );

   logic        accept;
   logic [15:0] half, ang_sum;
   logic        inwin;
   logic signed [16:0] t_raw;
   logic signed [W-1:0] mag0;
   logic signed [W-1:0] ox, oy;
   logic signed [25:0]  sx, sy;
   logic signed [15:0]  err_s;
   logic [15:0]         err_mag;
   logic signed [16:0]  turn_req;
   logic [16:0]         fwd_clip;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign half      = sweep_ff >> 1;
   assign inwin     = (req_sample_angle <= half) ||
                      ({1'b0, req_sample_angle} >= (17'h10000 - {1'b0, half}));
   assign ang_sum   = yaw_ff + bbear_ff;

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607)       r = 24'sh7FFFFF;
      else if (v < -26'sd8388608) r = 24'sh800000;
      else                        r = v[23:0];
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      lock_in = lock_ff; seen_in = seen_ff;
      lockx_in = lockx_ff; locky_in = locky_ff;
      brange_in = brange_ff; bbear_in = bbear_ff;
      px_in = px_ff; py_in = py_ff; yaw_in = yaw_ff;
      dx_in = dx_ff; dy_in = dy_ff; err_in = err_ff; zero_in = zero_ff;
      rv_in = rv_ff && rsp_stall;
      rfwd_in = rfwd_ff; rturn_in = rturn_ff; ral_in = ral_ff; rheld_in = rheld_ff;
      cctl = '{start: 1'b0, mode: MODE_ROTATE};
      cx0 = '0; cy0 = '0; cz0 = '0;
      t_raw = $signed({ang_sum[15], ang_sum});
      mag0 = W'(brange_ff) * W'(39797);
      ox = (cx + W'(32768)) >>> 16;
      oy = (cy + W'(32768)) >>> 16;
      sx = 26'(px_ff) + 26'(ox);
      sy = 26'(py_ff) + 26'(oy);
      err_s = err_ff;
      err_mag = err_s[15] ? 16'(-err_s) : err_ff;
      turn_req = '0;
      fwd_clip = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation) begin
                  lock_in = 1'b0;
               end else begin
                  if (!lock_ff && req_sample_present && inwin &&
                      (!seen_ff || req_sample_distance < brange_ff)) begin
                     brange_in = req_sample_distance;
                     bbear_in  = req_sample_angle;
                     seen_in   = 1'b1;
                  end
                  if (req_last_of_scan) begin
                     px_in = req_pose_x; py_in = req_pose_y; yaw_in = req_pose_yaw;
                     state_in = ST_LOCK;
                     // go through the rotation only when a lock will form
                     if (!lock_ff && seen_in && brange_in <= wall_ff) begin
                        state_in = ST_ROT_RUN;
                     end
                  end
               end
            end
         end
         ST_ROT_RUN: begin
            if (!cbusy && !cdone) begin
               cctl = '{start: 1'b1, mode: MODE_ROTATE};
               cx0 = mag0;
               if (t_raw > 17'sd16384) begin
                  t_raw = t_raw - 17'sd32768; cx0 = -mag0;
               end else if (t_raw < -17'sd16384) begin
                  t_raw = t_raw + 17'sd32768; cx0 = -mag0;
               end
               cz0 = $signed({t_raw, 16'h0});
            end else if (cdone) begin
               lockx_in = sat24(sx);
               locky_in = sat24(sy);
               lock_in  = 1'b1;
               state_in = ST_LOCK;
            end
         end
         ST_LOCK: begin
            seen_in = 1'b0; brange_in = 16'hFFFF; bbear_in = '0;
            dx_in = 25'(lockx_ff) - 25'(px_ff);
            dy_in = 25'(locky_ff) - 25'(py_ff);
            state_in = lock_ff ? ST_VEC_START : ST_DECIDE;
         end
         ST_VEC_START: begin
            zero_in = (dx_ff == 25'sd0) && (dy_ff == 25'sd0);
            cctl = '{start: 1'b1, mode: MODE_VECTOR};
            if (dx_ff[24]) begin
               cx0 = -(W'(dx_ff) <<< 8); cy0 = -(W'(dy_ff) <<< 8);
               cz0 = 33'sh080000000;
            end else begin
               cx0 = W'(dx_ff) <<< 8; cy0 = W'(dy_ff) <<< 8;
            end
            state_in = ST_VEC_RUN;
         end
         ST_VEC_RUN: begin
            if (cdone) begin
               err_in = (zero_ff ? 16'h0 : 16'((cz + 33'sd32768) >>> 16))
                        - yaw_ff - hset_ff;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // previous word still waiting: keep the result registers as they are
            if (!rv_ff) begin
               rheld_in = lock_ff;
               rfwd_in = '0; rturn_in = '0; ral_in = 1'b0;
               if (lock_ff) begin
                  if (err_mag < {1'b0, tol_ff}) begin
                     ral_in = 1'b1;
                  end else begin
                     turn_req = (err_s > 16'sd0) ? 17'(turn_ff) : -17'(turn_ff);
                     if (turn_req > $signed({2'b0, maxturn_ff}))
                        turn_req = $signed({2'b0, maxturn_ff});
                     if (turn_req < -$signed({2'b0, maxturn_ff}))
                        turn_req = -$signed({2'b0, maxturn_ff});
                     rturn_in = turn_req[15:0];
                  end
               end else begin
                  fwd_clip = fwd_ff[15] ? 17'd0 : 17'(fwd_ff);
                  if (fwd_clip > 17'(maxfwd_ff)) fwd_clip = 17'(maxfwd_ff);
                  rfwd_in = fwd_clip[14:0];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in; py_ff <= py_in; yaw_ff <= yaw_in;
      dx_ff <= dx_in; dy_ff <= dy_in; err_ff <= err_in; zero_ff <= zero_in;
      rfwd_ff <= rfwd_in; rturn_ff <= rturn_in; ral_ff <= ral_in; rheld_ff <= rheld_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         lock_ff <= 1'b0; seen_ff <= 1'b0;
         lockx_ff <= '0; locky_ff <= '0;
         brange_ff <= 16'hFFFF; bbear_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lock_ff <= lock_in; seen_ff <= seen_in;
         lockx_ff <= lockx_in; locky_ff <= locky_in;
         brange_ff <= brange_in; bbear_ff <= bbear_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_forward_velocity = rfwd_ff;
   assign rsp_turn_velocity    = rturn_ff;
   assign rsp_aligned          = ral_ff;
   assign rsp_target_held      = rheld_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("accept while busy");
   a_aligned_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_aligned |-> rsp_target_held) else $error("aligned without lock");
   a_held_no_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_held |-> rsp_forward_velocity == 15'd0)
      else $error("forward while held");

endmodule

// ===== dv/tb_nearest_wall_heading_aligner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_wall_heading_aligner: self-checking bench for the aligner
// Drives scan words with a local predictor of the nearest-sample tracker,
// the target lock (rotation CORDIC) and the heading decision (vectoring
// CORDIC); compares each response word field by field.
// ----------------------------------------------------------------------------
module tb_nearest_wall_heading_aligner;
   import nwha_pkg::*;

   localparam int Steps    = 16;
   localparam int TailWait = 2 * Steps + 20;
   localparam longint CycleLimit = 300000;

   typedef enum logic {OP_SAMPLE = 1'b0, OP_CLEAR = 1'b1} op_type;

   typedef struct packed {
      logic [14:0]        fwd;
      logic signed [15:0] turn;
      logic               aligned;
      logic               held;
   } steer_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic req_operation = 1'b0, req_sample_present = 1'b0, req_last_of_scan = 1'b0;
   logic [15:0] req_sample_angle = '0, req_sample_distance = '0, req_pose_yaw = '0;
   logic signed [23:0] req_pose_x = '0, req_pose_y = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [14:0] rsp_forward_velocity;
   logic signed [15:0] rsp_turn_velocity;
   logic rsp_aligned, rsp_target_held;
   logic csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   nearest_wall_heading_aligner #(.CORDIC_STEPS(Steps)) uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [15:0] p_sweep, p_wall_lim, p_tol_u, p_turn_spd, p_max_turn, p_max_fwd;
   logic signed [15:0] p_setpoint, p_fwd_spd;
   bit p_locked, p_seen;
   longint p_lock_x, p_lock_y;
   logic [15:0] p_best_range, p_best_bearing;

   steer_word_type expected_steer[$];
   int error_count = 0;
   longint cycle_count = 0;
   int stall_mode = 0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_step(int i);
      longint t[24] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
         64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
         64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30,
         64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return t[i];
   endfunction

   function automatic longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic void rotate_offset(input longint d, input logic [15:0] ang,
                                         output longint ox, output longint oy);
      longint t, x, y, z, nx;
      t = longint'(signed'(ang));
      x = d * 39797;
      y = 0;
      if (t > 16384) begin
         t -= 32768; x = -x;
      end else if (t < -16384) begin
         t += 32768; x = -x;
      end
      z = t * 65536;
      for (int i = 0; i < Steps; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_step(i);
         end else begin
            nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_step(i);
         end
         x = nx;
      end
      ox = floor_shr(x + 32768, 16);
      oy = floor_shr(y + 32768, 16);
   endfunction

   function automatic logic [15:0] bearing_to(longint dx, longint dy);
      longint x, y, z, nx;
      logic [63:0] r;
      x = dx * 256; y = dy * 256; z = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         x = -x; y = -y; z = 64'sd1 <<< 31;
      end
      for (int i = 0; i < Steps; i++) begin
         if (y >= 0) begin
            nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_step(i);
         end else begin
            nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_step(i);
         end
         x = nx;
      end
      r = floor_shr(z + 32768, 16);
      return r[15:0];
   endfunction

   task automatic predictor_reset();
      p_sweep = 16384; p_wall_lim = 512; p_setpoint = 0; p_tol_u = 182;
      p_turn_spd = 2048; p_fwd_spd = 410; p_max_turn = 11633; p_max_fwd = 901;
      p_locked = 0; p_lock_x = 0; p_lock_y = 0;
      p_best_range = 16'hFFFF; p_best_bearing = 0; p_seen = 0;
   endtask

   task automatic steer_predict(op_type op, bit present, logic [15:0] ang,
                                logic [15:0] rng, bit last, logic signed [23:0] px,
                                logic signed [23:0] py, logic [15:0] yaw);
      steer_word_type w;
      logic [15:0] half, b, e, bsum;
      longint ox, oy, err, mag, trn, fwd;
      w = '0;
      if (op == OP_CLEAR) begin
         p_locked = 0;
         return;
      end
      if (!p_locked && present) begin
         half = p_sweep >> 1;
         if ((ang <= half || 32'(ang) >= 65536 - 32'(half)) &&
             (!p_seen || rng < p_best_range)) begin
            p_best_range = rng; p_best_bearing = ang; p_seen = 1;
         end
      end
      if (!last) return;
      if (!p_locked && p_seen && p_best_range <= p_wall_lim) begin
         bsum = yaw + p_best_bearing;
         rotate_offset(longint'(p_best_range), bsum, ox, oy);
         p_lock_x = sat24(longint'(px) + ox);
         p_lock_y = sat24(longint'(py) + oy);
         p_locked = 1;
      end
      p_seen = 0; p_best_range = 16'hFFFF; p_best_bearing = 0;
      trn = 0; fwd = 0;
      if (p_locked) begin
         b = bearing_to(p_lock_x - longint'(px), p_lock_y - longint'(py));
         e = b - yaw - p_setpoint;
         err = longint'(signed'(e));
         mag = err < 0 ? -err : err;
         if (mag < longint'(p_tol_u[14:0])) begin
            w.aligned = 1;
         end else begin
            trn = err > 0 ? longint'(p_turn_spd[14:0]) : -longint'(p_turn_spd[14:0]);
            if (trn > longint'(p_max_turn[14:0])) trn = p_max_turn[14:0];
            if (trn < -longint'(p_max_turn[14:0])) trn = -longint'(p_max_turn[14:0]);
         end
      end else begin
         fwd = p_fwd_spd;
         if (fwd < 0) fwd = 0;
         if (fwd > longint'(p_max_fwd[14:0])) fwd = p_max_fwd[14:0];
      end
      w.fwd = fwd[14:0];
      w.turn = trn[15:0];
      w.held = p_locked;
      expected_steer.push_back(w);
   endtask

   // cycle limit and receiver stall pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb_nearest_wall_heading_aligner: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= (cycle_count % 16) < 11;
      endcase
   end

   // response checker
   always @(posedge clock) begin
      steer_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_steer.size() == 0) begin
            $error("unexpected response word");
            error_count++;
         end else begin
            want = expected_steer.pop_front();
            if (rsp_forward_velocity !== want.fwd) begin
               $error("forward_velocity exp %0d got %0d", want.fwd, rsp_forward_velocity);
               error_count++;
            end
            if (rsp_turn_velocity !== want.turn) begin
               $error("turn_velocity exp %0d got %0d", want.turn, rsp_turn_velocity);
               error_count++;
            end
            if (rsp_aligned !== want.aligned) begin
               $error("aligned exp %0d got %0d", want.aligned, rsp_aligned);
               error_count++;
            end
            if (rsp_target_held !== want.held) begin
               $error("target_held exp %0d got %0d", want.held, rsp_target_held);
               error_count++;
            end
         end
      end
   end

   // leaves req_valid high on return; a following send_word keeps it high, other callers lower it
   task automatic send_word(op_type op, bit present, logic [15:0] ang,
                            logic [15:0] rng, bit last, logic signed [23:0] px,
                            logic signed [23:0] py, logic [15:0] yaw);
      req_valid <= 1'b1;
      req_operation <= op; req_sample_present <= present;
      req_sample_angle <= ang; req_sample_distance <= rng;
      req_last_of_scan <= last; req_pose_x <= px; req_pose_y <= py;
      req_pose_yaw <= yaw;
      do @(posedge clock); while (req_stall);
      steer_predict(op, present, ang, rng, last, px, py, yaw);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_steer.size() != 0) @(negedge clock);
      repeat (TailWait) @(negedge clock);
   endtask

   // waits until no word is in flight, then writes the register and mirrors it in the predictor
   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      while (expected_steer.size() != 0) @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_SWEEP_RANGE:   p_sweep = val;
         REG_WALL_LIMIT:    p_wall_lim = val;
         REG_HEADING_SET:   p_setpoint = val;
         REG_ALIGN_TOL:     p_tol_u = {1'b0, val[14:0]};
         REG_TURN_SPEED:    p_turn_spd = {1'b0, val[14:0]};
         REG_FORWARD_SPEED: p_fwd_spd = val;
         REG_MAX_TURN:      p_max_turn = {1'b0, val[14:0]};
         REG_MAX_FORWARD:   p_max_fwd = {1'b0, val[14:0]};
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic scan_end(logic signed [23:0] px, logic signed [23:0] py,
                           logic [15:0] yaw);
      send_word(OP_SAMPLE, 1'b0, 16'h0, 16'h0, 1'b1, px, py, yaw);
   endtask

   task automatic test_directed();
      // no lock: forward clamp paths
      scan_end(0, 0, 0);
      write_reg(REG_FORWARD_SPEED, 16'h8000);
      scan_end(24'sh7FFFFF, -24'sh800000, 16'hFFFF);
      write_reg(REG_FORWARD_SPEED, 16'h7FFF);
      write_reg(REG_MAX_FORWARD, 16'h7FFF);
      scan_end(0, 0, 0);
      // window edges; first of equal ranges wins; the far sample does not replace it and the scan locks
      send_word(OP_SAMPLE, 1, 16'd8192, 16'd300, 0, 0, 0, 0);
      send_word(OP_SAMPLE, 1, 16'd8193, 16'd10, 0, 0, 0, 0);
      send_word(OP_SAMPLE, 1, 16'd57344, 16'd300, 0, 0, 0, 0);
      send_word(OP_SAMPLE, 1, 16'd0, 16'hFFFF, 1, 0, 0, 0);
      // samples are ignored while the lock is held
      send_word(OP_SAMPLE, 1, 16'd57344, 16'd200, 1, 24'sh7FFFFF, 24'sh7FFFFF, 16'd40000);
      send_word(OP_SAMPLE, 1, 16'd0, 16'd0, 1, 0, 0, 16'd123);
      // target at robot position gives heading zero
      send_word(OP_CLEAR, 1, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0);
      send_word(OP_SAMPLE, 1, 16'd0, 16'd0, 1, 24'sd100, -24'sd100, 0);
      drain();
      write_reg(REG_ALIGN_TOL, 16'h0);
      scan_end(24'sd100, -24'sd100, 0);
      drain();
      write_reg(REG_ALIGN_TOL, 16'h7FFF);
      write_reg(REG_TURN_SPEED, 16'h7FFF);
      write_reg(REG_MAX_TURN, 16'h0);
      write_reg(REG_HEADING_SET, 16'h8000);
      write_reg(REG_SWEEP_RANGE, 16'hFFFF);
      write_reg(REG_WALL_LIMIT, 16'hFFFF);
      send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_word(OP_SAMPLE, 1, 16'd32768, 16'hFFFF, 1, -24'sh800000, 24'sh7FFFFF, 16'd16384);
      scan_end(0, 0, 16'd5000);
      drain();
   endtask

   task automatic random_config();
      logic [15:0] v[8];
      for (int i = 0; i < 8; i++) begin
         v[i] = 16'($urandom_range(0, 65535));
         if ($urandom_range(0, 4) == 0) v[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      end
      v[1] = $urandom_range(0, 1) ? v[1] : 16'($urandom_range(0, 4096));
      v[3] = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : v[3];
      for (int i = 0; i < 8; i++) write_reg(CsrIndexWidth'(i), v[i]);
   endtask

   task automatic test_random_scans(int total);
      int sent = 0, burst;
      logic signed [23:0] px, py;
      logic [15:0] yaw, ang;
      while (sent < total) begin
         if (sent % 90 == 0) begin
            drain();
            random_config();
            stall_mode = (sent / 90) % 3;
         end
         px = $urandom_range(0, 3) == 0 ? 24'($urandom)
                                        : 24'($urandom_range(0, 8000)) - 24'd4000;
         py = $urandom_range(0, 3) == 0 ? 24'($urandom)
                                        : 24'($urandom_range(0, 8000)) - 24'd4000;
         yaw = 16'($urandom_range(0, 65535));
         burst = $urandom_range(0, 8);
         for (int k = 0; k <= burst; k++) begin
            ang = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1)) ang = 16'($urandom_range(0, 8192)) - 16'd4096;
            if ($urandom_range(0, 30) == 0)
               send_word(OP_CLEAR, 1'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom), px, py, yaw);
            else
               send_word(OP_SAMPLE, $urandom_range(0, 7) != 0, ang,
                         $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1500)),
                         k == burst, px, py, yaw);
            sent++;
         end
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else if (sent % 150 < 9 && expected_steer.size() != 0) begin
            req_valid <= 1'b0;
            while (expected_steer.size() != 0) @(negedge clock);
         end
      end
      drain();
   endtask

   initial begin
      predictor_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_scans(450);
      if (error_count == 0)
         $display("tb_nearest_wall_heading_aligner: done, clean");
      else
         $display("tb_nearest_wall_heading_aligner: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/nwha_pkg.sv
rtl/core/nwha_cordic.sv
rtl/core/nearest_wall_heading_aligner.sv
dv/tb_nearest_wall_heading_aligner.sv
